>>> rtl/sem_pkg.sv
// Shared types and constants for the Sobel edge-magnitude block.
// No dependencies; imported by the top level and the checker.
package sem_pkg;

    // Line-store geometry
    localparam int MaxWidth   = 2048;
    localparam int ColW       = $clog2(MaxWidth);
    localparam int WidthRegW  = 12;
    localparam int HeightRegW = 16;
    localparam int EffW       = (ColW + 1 > WidthRegW) ? ColW + 1 : WidthRegW;

    // Payload widths
    localparam int PixW     = 8;
    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 16;

    // Register reset values
    localparam logic [WidthRegW-1:0]  FrameWidthReset  = 12'd640;
    localparam logic [HeightRegW-1:0] FrameHeightReset = 16'd480;

    // Input item kinds
    localparam logic KindPixel = 1'b0;
    localparam logic KindDrain = 1'b1;

    typedef logic [ColW-1:0] col_t;
    typedef logic [PixW-1:0] pix_t;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CfgFrameWidth  = 1'b0,
        CfgFrameHeight = 1'b1
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_PX_RD,
        S_DR_RD0,
        S_DR_RD1,
        S_SQ,
        S_SUM,
        S_ROOT,
        S_RND,
        S_PUSH
    } sem_state_t;

endpackage

>>> rtl/sem_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sem_ram #(
    parameter int Width = 8,
    parameter int Depth = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/sobel_edge_magnitude_3x3.sv
// Streaming 3x3 Sobel gradient magnitude. Pixels arrive in raster order; the outputs for
// row r leave while row r+1 arrives (one per pixel but the first of a row, two on the
// last pixel of a row) and drain beats flush the last row, one output per drain beat.
// The block works on one beat at a time: a pixel or drain beat is accepted and read
// from the line stores (a wrong-phase beat goes straight to the output), and each output
// is squared, summed, rooted and rounded (root and rounding are skipped when the
// magnitude saturates), then pushed, where it can wait on a stalled output register. This
// pace is set by the single read port of each line store and by the shared magnitude
// unit, whose square root settles one bit per cycle. A finished output waits in an output
// register while the next beat is accepted.
// Depends on sem_pkg and sem_ram.
module sobel_edge_magnitude_3x3 (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [sem_pkg::PixW-1:0]      pixel,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sem_pkg::PixW-1:0]      magnitude,
    output logic                          end_of_line,
    output logic                          end_of_frame,
    output logic                          misuse,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sem_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [sem_pkg::CfgDataW-1:0]  cfg_data
);

    import sem_pkg::*;

    localparam logic [21:0] SatLimit = 22'd65280;

    // Sequencer
    sem_state_t state_reg, state_next;

    // Configuration and position
    logic [WidthRegW-1:0]  frame_width_reg;
    logic [HeightRegW-1:0] frame_height_reg;
    logic [HeightRegW-1:0] row_reg;
    col_t                  col_reg;
    logic                  draining_reg;
    logic                  more_reg;

    // Neighbourhood: [top, mid, bottom][left, centre, right]
    pix_t win_reg [3][3];

    // Per-beat payload
    col_t        c_reg;
    col_t        nx_reg;
    logic        last_reg;
    pix_t        px_reg;
    logic [20:0] sqx_reg;
    logic [20:0] sqy_reg;
    logic [15:0] s_reg;
    logic [7:0]  q_reg;
    logic [2:0]  idx_reg;
    pix_t        res_mag_reg;
    logic        res_eol_reg;
    logic        res_eof_reg;
    logic        res_mis_reg;

    // Output register
    logic        out_valid_reg;
    pix_t        magnitude_reg;
    logic        end_of_line_reg;
    logic        end_of_frame_reg;
    logic        misuse_reg;

    // Combinational helpers
    logic                  accept;
    logic                  wrong_phase;
    logic                  push_ok;
    logic [EffW-1:0]       fw_ext;
    logic [EffW-1:0]       eff_w;
    logic [EffW-1:0]       col_ext;
    logic [EffW-1:0]       c_ext;
    col_t                  c_in;
    logic                  last_in;
    col_t                  nx_in;
    logic [HeightRegW-1:0] eff_h;
    logic                  last_row;
    pix_t                  older_q;
    pix_t                  recent_q;
    pix_t                  mid_px;
    pix_t                  top_px;
    pix_t                  top_dr;
    logic                  ram_we;
    col_t                  rd_addr;
    logic [11:0]           sum_top;
    logic [11:0]           sum_bot;
    logic [11:0]           sum_lft;
    logic [11:0]           sum_rgt;
    logic signed [11:0]    gx;
    logic signed [11:0]    gy;
    logic signed [23:0]    gx_sq;
    logic signed [23:0]    gy_sq;
    logic [21:0]           s_sum;
    logic [7:0]            q_try;
    logic [15:0]           q_try_sq;
    logic [16:0]           q_bound;
    logic [8:0]            q_rnd;

    // Line stores
    sem_ram #(.Width(PixW), .Depth(MaxWidth)) u_older_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (c_reg),
        .wdata (recent_q),
        .raddr (rd_addr),
        .rdata (older_q)
    );

    sem_ram #(.Width(PixW), .Depth(MaxWidth)) u_recent_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (c_reg),
        .wdata (px_reg),
        .raddr (rd_addr),
        .rdata (recent_q)
    );

    // Effective geometry and clamped column for the arriving beat
    always_comb
    begin
        fw_ext = EffW'(frame_width_reg);
        if (fw_ext == '0)
            eff_w = EffW'(1);
        else if (fw_ext > EffW'(MaxWidth))
            eff_w = EffW'(MaxWidth);
        else
            eff_w = fw_ext;
        col_ext = EffW'(col_reg);
        c_ext   = (col_ext >= eff_w) ? eff_w - EffW'(1) : col_ext;
        c_in    = c_ext[ColW-1:0];
        last_in = (c_ext == eff_w - EffW'(1));
        nx_in   = last_in ? c_in : c_in + col_t'(1);
        eff_h   = (frame_height_reg == '0) ? HeightRegW'(1) : frame_height_reg;
        last_row = (row_reg >= eff_h - HeightRegW'(1));
    end

    // Handshake terms
    assign accept      = (state_reg == S_IDLE) && in_valid;
    assign wrong_phase = (kind != draining_reg);
    assign push_ok     = (state_reg == S_PUSH) && (!out_valid_reg || !out_stall);

    // Line-store read data selection
    assign mid_px = recent_q;
    assign top_px = (row_reg <= HeightRegW'(1)) ? recent_q : older_q;
    assign top_dr = (row_reg == '0) ? recent_q : older_q;

    // Gradients over the window
    always_comb
    begin
        sum_top = 12'(win_reg[0][0]) + (12'(win_reg[0][1]) << 1) + 12'(win_reg[0][2]);
        sum_bot = 12'(win_reg[2][0]) + (12'(win_reg[2][1]) << 1) + 12'(win_reg[2][2]);
        sum_lft = 12'(win_reg[0][0]) + (12'(win_reg[1][0]) << 1) + 12'(win_reg[2][0]);
        sum_rgt = 12'(win_reg[0][2]) + (12'(win_reg[1][2]) << 1) + 12'(win_reg[2][2]);
        gx      = signed'(sum_bot - sum_top);
        gy      = signed'(sum_rgt - sum_lft);
        gx_sq   = gx * gx;
        gy_sq   = gy * gy;
    end

    // Magnitude unit: sum, one root bit per cycle, rounding
    always_comb
    begin
        s_sum    = 22'(sqx_reg) + 22'(sqy_reg);
        q_try    = q_reg | (8'd1 << idx_reg);
        q_try_sq = 16'(q_try) * 16'(q_try);
        q_bound  = 17'(q_reg) * 17'(q_reg) + 17'(q_reg);
        q_rnd    = (17'(s_reg) > q_bound) ? 9'(q_reg) + 9'd1 : 9'(q_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (wrong_phase)
                        state_next = S_PUSH;
                    else if (kind == KindPixel)
                        state_next = S_PX_RD;
                    else if (c_in == '0)
                        state_next = S_DR_RD0;
                    else
                        state_next = S_DR_RD1;
                end
            end
            S_PX_RD:
            begin
                if (row_reg != '0 && (c_reg != '0 || last_reg))
                    state_next = S_SQ;
                else
                    state_next = S_IDLE;
            end
            S_DR_RD0: state_next = S_DR_RD1;
            S_DR_RD1: state_next = S_SQ;
            S_SQ:     state_next = S_SUM;
            S_SUM:    state_next = (s_sum > SatLimit) ? S_PUSH : S_ROOT;
            S_ROOT:
            begin
                if (idx_reg == '0)
                    state_next = S_RND;
            end
            S_RND:    state_next = S_PUSH;
            S_PUSH:
            begin
                if (push_ok)
                    state_next = more_reg ? S_SQ : S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_stall = 1'b1;
        ram_we   = 1'b0;
        rd_addr  = c_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                rd_addr  = (kind == KindDrain && c_in != '0) ? nx_in : c_in;
            end
            S_PX_RD:  ram_we  = 1'b1;
            S_DR_RD0: rd_addr = nx_reg;
            default:  rd_addr = c_reg;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            frame_width_reg  <= FrameWidthReset;
            frame_height_reg <= FrameHeightReset;
            row_reg          <= '0;
            col_reg          <= '0;
            draining_reg     <= 1'b0;
            more_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[r][k] <= '0;
                end
            end
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_valid)
            begin
                case (cfg_index)
                    CfgFrameWidth:  frame_width_reg  <= cfg_data[WidthRegW-1:0];
                    CfgFrameHeight: frame_height_reg <= cfg_data[HeightRegW-1:0];
                    default:        ;
                endcase
            end

            // output register occupancy
            if (push_ok)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_PX_RD:
                begin
                    // window update with the new column
                    if (c_reg == '0)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            win_reg[0][k] <= top_px;
                            win_reg[1][k] <= mid_px;
                            win_reg[2][k] <= px_reg;
                        end
                    end
                    else
                    begin
                        for (int r = 0; r < 3; r++)
                        begin
                            win_reg[r][0] <= win_reg[r][1];
                            win_reg[r][1] <= win_reg[r][2];
                        end
                        win_reg[0][2] <= top_px;
                        win_reg[1][2] <= mid_px;
                        win_reg[2][2] <= px_reg;
                    end
                    more_reg <= (row_reg != '0) && (c_reg != '0) && last_reg;
                    // position advance
                    if (last_reg)
                    begin
                        col_reg <= '0;
                        if (last_row)
                            draining_reg <= 1'b1;
                        else
                            row_reg <= row_reg + HeightRegW'(1);
                    end
                    else
                    begin
                        col_reg <= c_reg + col_t'(1);
                    end
                end
                S_DR_RD0:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        win_reg[0][k] <= top_dr;
                        win_reg[1][k] <= recent_q;
                        win_reg[2][k] <= recent_q;
                    end
                end
                S_DR_RD1:
                begin
                    for (int r = 0; r < 3; r++)
                    begin
                        win_reg[r][0] <= win_reg[r][1];
                        win_reg[r][1] <= win_reg[r][2];
                    end
                    win_reg[0][2] <= top_dr;
                    win_reg[1][2] <= recent_q;
                    win_reg[2][2] <= recent_q;
                    more_reg      <= 1'b0;
                    if (last_reg)
                    begin
                        col_reg      <= '0;
                        row_reg      <= '0;
                        draining_reg <= 1'b0;
                    end
                    else
                    begin
                        col_reg <= c_reg + col_t'(1);
                    end
                end
                S_PUSH:
                begin
                    // row end: replicate the right column for the second output
                    if (push_ok && more_reg)
                    begin
                        for (int r = 0; r < 3; r++)
                        begin
                            win_reg[r][0] <= win_reg[r][1];
                            win_reg[r][1] <= win_reg[r][2];
                        end
                        more_reg <= 1'b0;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                        more_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Beat payload and magnitude datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    c_reg       <= c_in;
                    nx_reg      <= nx_in;
                    last_reg    <= last_in;
                    px_reg      <= pixel;
                    res_mag_reg <= '0;
                    res_eol_reg <= 1'b0;
                    res_eof_reg <= 1'b0;
                    res_mis_reg <= wrong_phase;
                end
            end
            S_PX_RD:
            begin
                // a lone output at column zero is the row end
                res_eol_reg <= (c_reg == '0);
                res_eof_reg <= 1'b0;
                res_mis_reg <= 1'b0;
            end
            S_DR_RD1:
            begin
                res_eol_reg <= last_reg;
                res_eof_reg <= last_reg;
                res_mis_reg <= 1'b0;
            end
            S_SQ:
            begin
                sqx_reg <= gx_sq[20:0];
                sqy_reg <= gy_sq[20:0];
            end
            S_SUM:
            begin
                if (s_sum > SatLimit)
                    res_mag_reg <= '1;
                s_reg   <= s_sum[15:0];
                q_reg   <= '0;
                idx_reg <= 3'd7;
            end
            S_ROOT:
            begin
                if (q_try_sq <= s_reg)
                    q_reg <= q_try;
                idx_reg <= idx_reg - 3'd1;
            end
            S_RND:
            begin
                res_mag_reg <= q_rnd[8] ? '1 : q_rnd[7:0];
            end
            S_PUSH:
            begin
                if (push_ok)
                begin
                    magnitude_reg    <= res_mag_reg;
                    end_of_line_reg  <= res_eol_reg;
                    end_of_frame_reg <= res_eof_reg;
                    misuse_reg       <= res_mis_reg;
                    if (more_reg)
                    begin
                        res_eol_reg <= 1'b1;
                        res_eof_reg <= 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    // Ports
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign magnitude    = magnitude_reg;
    assign end_of_line  = end_of_line_reg;
    assign end_of_frame = end_of_frame_reg;
    assign misuse       = misuse_reg;

endmodule

>>> rtl/sem_checker.sv
// Port-level checks for the Sobel edge-magnitude block, bound to the top level.
// Depends on sem_pkg and sobel_edge_magnitude_3x3.
module sem_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic [sem_pkg::PixW-1:0] magnitude,
    input logic                     end_of_line,
    input logic                     end_of_frame,
    input logic                     misuse
);

    import sem_pkg::*;

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(magnitude)
            && $stable(end_of_line) && $stable(end_of_frame) && $stable(misuse))
        else $error("output beat changed while stalled");

    // A dropped beat carries nothing but its flag
    a_misuse_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && misuse |-> magnitude == '0 && !end_of_line && !end_of_frame)
        else $error("misuse beat carries data");

    // Frame end is always a row end
    a_eof_eol: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_frame |-> end_of_line)
        else $error("frame end without row end");

    // One beat in work at a time
    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a beat is in work");

endmodule

bind sobel_edge_magnitude_3x3 sem_checker u_sem_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .magnitude    (magnitude),
    .end_of_line  (end_of_line),
    .end_of_frame (end_of_frame),
    .misuse       (misuse)
);
